// ===== hw/rtl/pedestrian_crossing_signal_fsm_top_macros.svh =====
// Assertion macros for the pedestrian crossing signal RTL.
`ifndef PEDESTRIAN_CROSSING_SIGNAL_FSM_TOP_MACROS_SVH
`define PEDESTRIAN_CROSSING_SIGNAL_FSM_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PCS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PCS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PCS_ASSERT_IMP(lbl, ante, cons, msg)
`define PCS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/pcs_pkg.sv =====
// Types and constants of the pedestrian crossing signal controller.
`timescale 1ns / 1ps
`default_nettype none
package pcs_pkg;

    typedef struct packed {
        logic        button_press;
        logic        auto_enable;
        logic [1:0]  light_phase;
        logic [15:0] phase_time_left;
    } tick_t;

    typedef struct packed {
        logic       red_lamp;
        logic       green_lamp;
        logic [9:0] buzzer_level;
        logic [2:0] walk_state;
    } result_t;

    typedef struct packed {
        logic [9:0]  tick_ms;
        logic [15:0] stop_period;
        logic [15:0] allow_period;
        logic [9:0]  stop_pulse;
        logic [9:0]  allow_pulse;
        logic [15:0] louder_threshold;
        logic [15:0] blink_period;
    } cfg_t;

    typedef enum logic [2:0] {
        CFG_TICK_MS          = 3'd0,
        CFG_STOP_PERIOD      = 3'd1,
        CFG_ALLOW_PERIOD     = 3'd2,
        CFG_STOP_PULSE       = 3'd3,
        CFG_ALLOW_PULSE      = 3'd4,
        CFG_LOUDER_THRESHOLD = 3'd5,
        CFG_BLINK_PERIOD     = 3'd6
    } cfg_idx_t;

    typedef enum logic [4:0] {
        MODE_OFF   = 5'b00001,
        MODE_REQ   = 5'b00010,
        MODE_STOP  = 5'b00100,
        MODE_ALLOW = 5'b01000,
        MODE_LOUD  = 5'b10000
    } mode_t;

    localparam logic [2:0] WS_OFF   = 3'd0;
    localparam logic [2:0] WS_REQ   = 3'd1;
    localparam logic [2:0] WS_STOP  = 3'd2;
    localparam logic [2:0] WS_ALLOW = 3'd3;
    localparam logic [2:0] WS_LOUD  = 3'd4;

    localparam logic [1:0] PH_GREEN  = 2'd0;
    localparam logic [1:0] PH_YELLOW = 2'd1;
    localparam logic [1:0] PH_RED    = 2'd2;

    localparam logic [15:0] INTERVAL_STEP   = 16'd200;
    localparam logic [15:0] INTERVAL_REDUCE = 16'd400;
    localparam logic [10:0] PULSE_STEP      = 11'd100;
    localparam logic [10:0] PULSE_CAP       = 11'd950;
    localparam logic [10:0] PULSE_MAX       = 11'd1023;

    localparam cfg_t CFG_RESET = '{
        tick_ms:          10'd10,
        stop_period:      16'd1000,
        allow_period:     16'd500,
        stop_pulse:       10'd300,
        allow_pulse:      10'd500,
        louder_threshold: 16'd3,
        blink_period:     16'd250
    };

endpackage
`default_nettype wire

// ===== hw/rtl/pcs_cfg_regs.sv =====
// Configuration register file of the pedestrian crossing signal controller.
`timescale 1ns / 1ps
`default_nettype none
module pcs_cfg_regs
    import pcs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TICK_MS:          cfg_next.tick_ms          = cfg_data[9:0];
                CFG_STOP_PERIOD:      cfg_next.stop_period      = cfg_data;
                CFG_ALLOW_PERIOD:     cfg_next.allow_period     = cfg_data;
                CFG_STOP_PULSE:       cfg_next.stop_pulse       = cfg_data[9:0];
                CFG_ALLOW_PULSE:      cfg_next.allow_pulse      = cfg_data[9:0];
                CFG_LOUDER_THRESHOLD: cfg_next.louder_threshold = cfg_data;
                CFG_BLINK_PERIOD:     cfg_next.blink_period     = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/pcs_core.sv =====
// Mode state machine, beep and blink timers of one crossing direction.
`timescale 1ns / 1ps
`default_nettype none
module pcs_core
    import pcs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  advance,
    input  wire tick_t tick,
    output result_t    res
);

    mode_t       mode_reg,          mode_next;
    logic        beep_on_reg,       beep_on_next;
    logic [15:0] beep_timer_reg,    beep_timer_next;
    logic [15:0] blink_timer_reg,   blink_timer_next;
    logic [15:0] beep_interval_reg, beep_interval_next;
    logic [9:0]  beep_pulse_reg,    beep_pulse_next;
    logic        green_held_reg,    green_held_next;
    logic [9:0]  compare_held_reg,  compare_held_next;
    logic        red;
    logic [10:0] pulse_sum;
    logic [2:0]  walk;

    function automatic logic [15:0] count_down(input logic [15:0] t, input logic [9:0] step);
        logic [15:0] s;
        s = {6'd0, step};
        return (t > s) ? (t - s) : 16'd0;
    endfunction

    always_comb
    begin
        mode_next          = mode_reg;
        beep_on_next       = beep_on_reg;
        beep_interval_next = beep_interval_reg;
        beep_pulse_next    = beep_pulse_reg;
        green_held_next    = green_held_reg;
        compare_held_next  = compare_held_reg;
        beep_timer_next    = count_down(beep_timer_reg, cfg.tick_ms);
        blink_timer_next   = count_down(blink_timer_reg, cfg.tick_ms);
        red                = 1'b0;
        pulse_sum          = '0;

        // transition and entry actions
        unique case (mode_reg)
            MODE_REQ:
            begin
                if (tick.light_phase == PH_GREEN || tick.light_phase == PH_YELLOW)
                begin
                    beep_timer_next   = cfg.stop_period;
                    compare_held_next = cfg.stop_pulse;
                    beep_on_next      = 1'b1;
                    mode_next         = MODE_STOP;
                end
                else if (tick.light_phase == PH_RED)
                begin
                    beep_timer_next   = cfg.allow_period;
                    compare_held_next = cfg.allow_pulse;
                    beep_on_next      = 1'b1;
                    mode_next         = MODE_ALLOW;
                end
                if (!tick.auto_enable)
                begin
                    mode_next = MODE_OFF;
                end
            end
            MODE_STOP:
            begin
                if (tick.light_phase == PH_RED)
                begin
                    beep_timer_next   = cfg.allow_period;
                    compare_held_next = cfg.allow_pulse;
                    beep_on_next      = 1'b1;
                    mode_next         = MODE_ALLOW;
                end
                if (!tick.auto_enable)
                begin
                    mode_next = MODE_OFF;
                end
            end
            MODE_ALLOW:
            begin
                if (tick.phase_time_left <= cfg.louder_threshold && tick.auto_enable)
                begin
                    blink_timer_next   = cfg.blink_period;
                    beep_interval_next = (cfg.allow_period >= INTERVAL_STEP)
                                         ? cfg.allow_period - INTERVAL_STEP : 16'd0;
                    pulse_sum          = {1'b0, cfg.allow_pulse} + PULSE_STEP;
                    beep_pulse_next    = (pulse_sum > PULSE_MAX) ? 10'h3ff : pulse_sum[9:0];
                    beep_timer_next    = beep_interval_next;
                    compare_held_next  = beep_pulse_next;
                    beep_on_next       = 1'b1;
                    mode_next          = MODE_LOUD;
                end
                if (!tick.auto_enable)
                begin
                    mode_next = MODE_OFF;
                end
            end
            MODE_LOUD:
            begin
                if (tick.light_phase == PH_GREEN || !tick.auto_enable)
                begin
                    mode_next = MODE_OFF;
                end
            end
            default:
            begin
                mode_next = (tick.button_press && tick.auto_enable) ? MODE_REQ : MODE_OFF;
            end
        endcase

        // action of the new state
        unique case (mode_next)
            MODE_STOP:
            begin
                red             = 1'b1;
                green_held_next = 1'b0;
                if (beep_timer_next == 16'd0)
                begin
                    beep_timer_next   = cfg.stop_period;
                    beep_on_next      = !beep_on_next;
                    compare_held_next = beep_on_next ? cfg.stop_pulse : 10'd0;
                end
            end
            MODE_ALLOW:
            begin
                green_held_next = 1'b1;
                if (beep_timer_next == 16'd0)
                begin
                    beep_timer_next   = cfg.allow_period;
                    beep_on_next      = !beep_on_next;
                    compare_held_next = beep_on_next ? cfg.allow_pulse : 10'd0;
                end
            end
            MODE_LOUD:
            begin
                if (blink_timer_next == 16'd0)
                begin
                    blink_timer_next = cfg.blink_period;
                    green_held_next  = !green_held_next;
                end
                if (beep_timer_next == 16'd0)
                begin
                    if (beep_on_next)
                    begin
                        beep_on_next      = 1'b0;
                        compare_held_next = 10'd0;
                    end
                    else
                    begin
                        // shorter and louder with each new beep
                        beep_on_next = 1'b1;
                        if (beep_interval_next >= INTERVAL_REDUCE)
                        begin
                            beep_interval_next = beep_interval_next - INTERVAL_STEP;
                        end
                        if (({1'b0, beep_pulse_next} + PULSE_STEP) <= PULSE_CAP)
                        begin
                            beep_pulse_next = beep_pulse_next + PULSE_STEP[9:0];
                        end
                        compare_held_next = beep_pulse_next;
                    end
                    beep_timer_next = beep_interval_next;
                end
            end
            default:
            begin
                green_held_next   = 1'b0;
                compare_held_next = 10'd0;
            end
        endcase
    end

    always_comb
    begin
        unique case (mode_next)
            MODE_REQ:   walk = WS_REQ;
            MODE_STOP:  walk = WS_STOP;
            MODE_ALLOW: walk = WS_ALLOW;
            MODE_LOUD:  walk = WS_LOUD;
            default:    walk = WS_OFF;
        endcase
    end

    assign res.red_lamp     = red;
    assign res.green_lamp   = green_held_next;
    assign res.buzzer_level = compare_held_next;
    assign res.walk_state   = walk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_OFF;
            beep_on_reg       <= 1'b0;
            beep_timer_reg    <= 16'd0;
            blink_timer_reg   <= 16'd0;
            beep_interval_reg <= CFG_RESET.stop_period;
            beep_pulse_reg    <= CFG_RESET.stop_pulse;
            green_held_reg    <= 1'b0;
            compare_held_reg  <= 10'd0;
        end
        else if (advance)
        begin
            mode_reg          <= mode_next;
            beep_on_reg       <= beep_on_next;
            beep_timer_reg    <= beep_timer_next;
            blink_timer_reg   <= blink_timer_next;
            beep_interval_reg <= beep_interval_next;
            beep_pulse_reg    <= beep_pulse_next;
            green_held_reg    <= green_held_next;
            compare_held_reg  <= compare_held_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/pedestrian_crossing_signal_fsm_top.sv =====
// Pedestrian crossing signal controller for one crossing direction.
//
// Tick channel: tick_valid / tick_stall / tick carry one scheduler tick
// (button event, auto mode, vehicle light phase, time left in phase). A
// transfer happens on a rising edge with tick_valid high and tick_stall low.
// Result channel: res_valid / res_stall / res give one result per tick
// (red lamp, green lamp, buzzer compare value, walk state code).
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write only while no tick is in flight.
// Path: a tick is registered in the tick register, evaluated against the mode
// and timer state, and its result is registered in the result register that
// drives res. Throughput: one tick per cycle unless the result stalls; the
// state update is a single pass of count-down, transition and action logic.
// Reset: mode off, timers expired, lamps dark, buzzer silent, configuration
// back to its reset values, both pipeline registers empty.
// Receiver stall: the result register holds; the tick register holds its
// tick behind it, and tick_stall rises while both are full and stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "pedestrian_crossing_signal_fsm_top_macros.svh"
module pedestrian_crossing_signal_fsm_top
    import pcs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        tick_valid,
    output logic             tick_stall,
    input  wire tick_t       tick,
    output logic             res_valid,
    input  wire logic        res_stall,
    output result_t          res,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    cfg_t    cfg;
    logic    s1_valid_reg, s1_valid_next;
    tick_t   s1_data_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg;
    result_t core_res;
    logic    advance;
    logic    take;

    pcs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pcs_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .tick    (s1_data_reg),
        .res     (core_res)
    );

    // move the registered tick into the result register when it has room
    assign advance    = s1_valid_reg && (!out_valid_reg || !res_stall);
    assign tick_stall = s1_valid_reg && !advance;
    assign take       = tick_valid && !tick_stall;

    assign res_valid = out_valid_reg;
    assign res       = out_data_reg;

    always_comb
    begin
        s1_valid_next  = take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        out_valid_next = advance ? 1'b1 : (res_stall ? out_valid_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_data_reg <= tick;
        end
        if (advance)
        begin
            out_data_reg <= core_res;
        end
    end

    `PCS_ASSERT_NXT(a_stall_holds_tick, tick_stall, s1_valid_reg,
                    "stalled tick dropped from input register")
    `PCS_ASSERT_NXT(a_advance_fills_out, advance, out_valid_reg,
                    "evaluated tick did not reach result register")
    `PCS_ASSERT_IMP(a_stall_cause, tick_stall, out_valid_reg && res_stall,
                    "tick stall without a blocked result")
    `PCS_ASSERT_IMP(a_lamps_exclusive, out_valid_reg,
                    !(out_data_reg.red_lamp && out_data_reg.green_lamp),
                    "red and green lamps on together")

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the pedestrian crossing signal controller.
`timescale 1ns / 1ps
module tb_top;
    import pcs_pkg::*;

    localparam logic [1:0]  PH_OTHER     = 2'd3;
    localparam logic [2:0]  CFG_SPARE    = 3'd7;
    localparam logic [15:0] SPAN_STEP    = 16'd200;
    localparam logic [15:0] SPAN_FLOOR   = 16'd200;
    localparam logic [10:0] LEVEL_STEP   = 11'd100;
    localparam logic [10:0] LEVEL_CAP    = 11'd950;
    localparam logic [10:0] LEVEL_TOP    = 11'd1023;
    localparam int          QUIET_LIMIT  = 2000;
    localparam int          RANDOM_TICKS = 72;
    localparam int          PHASES       = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        tick_valid = 1'b0;
    logic        tick_stall;
    tick_t       tick = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    result_t     res;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // controller state as predicted, plus the register values it runs with
    cfg_t        shadow_cfg = '{
        tick_ms:          10'd10,
        stop_period:      16'd1000,
        allow_period:     16'd500,
        stop_pulse:       10'd300,
        allow_pulse:      10'd500,
        louder_threshold: 16'd3,
        blink_period:     16'd250
    };
    mode_t       sig_mode = MODE_OFF;
    logic        tone_on = 1'b0;
    logic [15:0] tone_left = '0;
    logic [15:0] flash_left = '0;
    logic [15:0] tone_span = 16'd1000;
    logic [9:0]  tone_level = 10'd300;
    logic        walk_lit = 1'b0;
    logic [9:0]  buzz_cmp = '0;

    tick_t       pending_ticks[$];
    result_t     expected_lamps[$];
    int          queued_count = 0;
    int          drop_countdown = -1;
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    bit          steady = 1'b0;

    pedestrian_crossing_signal_fsm_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .tick       (tick),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] run_down(logic [15:0] t);
        logic [15:0] step;
        step = {6'd0, shadow_cfg.tick_ms};
        return (t > step) ? t - step : 16'd0;
    endfunction

    function automatic void start_tone(logic [15:0] span, logic [9:0] level, mode_t nxt);
        tone_left = span;
        buzz_cmp  = level;
        tone_on   = 1'b1;
        sig_mode  = nxt;
    endfunction

    function automatic void toggle_tone(logic [15:0] span, logic [9:0] level);
        if (tone_left == 16'd0)
        begin
            tone_left = span;
            tone_on   = ~tone_on;
            buzz_cmp  = tone_on ? level : 10'd0;
        end
    endfunction

    // advance the controller by one tick and return the lamp/buzzer outputs
    function automatic result_t walk_advance(tick_t t);
        result_t     r;
        logic        red;
        logic [10:0] lvl;
        red = 1'b0;
        tone_left  = run_down(tone_left);
        flash_left = run_down(flash_left);

        case (sig_mode)
            MODE_REQ:
            begin
                if (t.light_phase == PH_GREEN || t.light_phase == PH_YELLOW)
                    start_tone(shadow_cfg.stop_period, shadow_cfg.stop_pulse, MODE_STOP);
                else if (t.light_phase == PH_RED)
                    start_tone(shadow_cfg.allow_period, shadow_cfg.allow_pulse, MODE_ALLOW);
                if (!t.auto_enable)
                    sig_mode = MODE_OFF;
            end
            MODE_STOP:
            begin
                if (t.light_phase == PH_RED)
                    start_tone(shadow_cfg.allow_period, shadow_cfg.allow_pulse, MODE_ALLOW);
                if (!t.auto_enable)
                    sig_mode = MODE_OFF;
            end
            MODE_ALLOW:
            begin
                if (t.phase_time_left <= shadow_cfg.louder_threshold && t.auto_enable)
                begin
                    flash_left = shadow_cfg.blink_period;
                    tone_span = (shadow_cfg.allow_period >= SPAN_STEP) ?
                                shadow_cfg.allow_period - SPAN_STEP : 16'd0;
                    lvl = {1'b0, shadow_cfg.allow_pulse} + LEVEL_STEP;
                    tone_level = (lvl > LEVEL_TOP) ? LEVEL_TOP[9:0] : lvl[9:0];
                    start_tone(tone_span, tone_level, MODE_LOUD);
                end
                if (!t.auto_enable)
                    sig_mode = MODE_OFF;
            end
            MODE_LOUD:
            begin
                if (t.light_phase == PH_GREEN || !t.auto_enable)
                    sig_mode = MODE_OFF;
            end
            default:
            begin
                sig_mode = (t.button_press && t.auto_enable) ? MODE_REQ : MODE_OFF;
            end
        endcase

        case (sig_mode)
            MODE_STOP:
            begin
                red = 1'b1;
                walk_lit = 1'b0;
                toggle_tone(shadow_cfg.stop_period, shadow_cfg.stop_pulse);
            end
            MODE_ALLOW:
            begin
                walk_lit = 1'b1;
                toggle_tone(shadow_cfg.allow_period, shadow_cfg.allow_pulse);
            end
            MODE_LOUD:
            begin
                if (flash_left == 16'd0)
                begin
                    flash_left = shadow_cfg.blink_period;
                    walk_lit = ~walk_lit;
                end
                if (tone_left == 16'd0)
                begin
                    if (tone_on)
                    begin
                        tone_on  = 1'b0;
                        buzz_cmp = 10'd0;
                    end
                    else
                    begin
                        // shorter and louder with every new beep
                        tone_on = 1'b1;
                        if (tone_span >= SPAN_FLOOR + SPAN_STEP)
                            tone_span = tone_span - SPAN_STEP;
                        lvl = {1'b0, tone_level} + LEVEL_STEP;
                        if (lvl <= LEVEL_CAP)
                            tone_level = lvl[9:0];
                        buzz_cmp = tone_level;
                    end
                    tone_left = tone_span;
                end
            end
            default:
            begin
                walk_lit = 1'b0;
                buzz_cmp = 10'd0;
            end
        endcase

        r.red_lamp     = red;
        r.green_lamp   = walk_lit;
        r.buzzer_level = buzz_cmp;
        case (sig_mode)
            MODE_REQ:   r.walk_state = WS_REQ;
            MODE_STOP:  r.walk_state = WS_STOP;
            MODE_ALLOW: r.walk_state = WS_ALLOW;
            MODE_LOUD:  r.walk_state = WS_LOUD;
            default:    r.walk_state = WS_OFF;
        endcase
        return r;
    endfunction

    // tick driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid <= 1'b0;
            tick       <= '0;
        end
        else
        begin
            if (tick_valid && !tick_stall)
                expected_lamps.push_back(walk_advance(tick));
            if (!tick_valid || !tick_stall)
            begin
                if (pending_ticks.size() != 0 && (steady || $urandom_range(99) >= 37))
                begin
                    tick_valid <= 1'b1;
                    tick       <= pending_ticks.pop_front();
                end
                else
                    tick_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else
            res_stall <= !steady && ($urandom_range(99) < 37);
    end

    function automatic void check_field(string what, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            mismatch_count++;
        end
    endfunction

    // result monitor
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_lamps.size() == 0)
            begin
                $display("%0t: result %p expected nothing, got a transfer", $time, res);
                mismatch_count++;
            end
            else
            begin
                want = expected_lamps.pop_front();
                check_field("red_lamp", int'(want.red_lamp), int'(res.red_lamp));
                check_field("green_lamp", int'(want.green_lamp), int'(res.green_lamp));
                check_field("buzzer_level", int'(want.buzzer_level), int'(res.buzzer_level));
                check_field("walk_state", int'(want.walk_state), int'(res.walk_state));
            end
        end
    end

    // watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((tick_valid && !tick_stall) || (res_valid && !res_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic bit coin();
        return 1'($urandom_range(1));
    endfunction

    function automatic logic [15:0] any16();
        return 16'($urandom);
    endfunction

    function automatic logic [1:0] any_phase();
        return 2'($urandom_range(3));
    endfunction

    function automatic logic [1:0] held_phase();
        logic [1:0] p;
        p = any_phase();
        if (p == PH_GREEN)
            p = PH_RED;
        return p;
    endfunction

    function automatic tick_t mk_tick(logic press, logic auto_on, logic [1:0] phase,
                                      logic [15:0] remain);
        tick_t t;
        t.button_press    = press;
        t.auto_enable     = auto_on;
        t.light_phase     = phase;
        t.phase_time_left = remain;
        return t;
    endfunction

    // broken sequences drop auto mode somewhere along the way
    function automatic void queue_tick(tick_t t);
        if (drop_countdown == 0)
            t.auto_enable = 1'b0;
        if (drop_countdown >= 0)
            drop_countdown--;
        pending_ticks.push_back(t);
        queued_count++;
    endfunction

    // one full crossing: request, wait, optional stop, allow, louder, exit
    function automatic void queue_crossing();
        int thr;
        int remain;
        thr = int'(shadow_cfg.louder_threshold);
        drop_countdown = ($urandom_range(99) < 15) ? int'($urandom_range(0, 30)) : -1;
        repeat ($urandom_range(0, 2))
            queue_tick(mk_tick(1'b0, 1'b1, any_phase(), any16()));
        queue_tick(mk_tick(1'b1, 1'b1, any_phase(), any16()));
        repeat ($urandom_range(0, 3))
            queue_tick(mk_tick(coin(), 1'b1, PH_OTHER, any16()));
        if (coin())
            repeat ($urandom_range(1, 8))
                queue_tick(mk_tick(coin(), 1'b1, coin() ? PH_GREEN : PH_YELLOW, any16()));
        remain = thr + int'($urandom_range(1, 10));
        if (remain > 65535)
            remain = 65535;
        queue_tick(mk_tick(coin(), 1'b1, PH_RED, 16'(remain)));
        while (remain > thr)
        begin
            remain--;
            queue_tick(mk_tick(coin(), 1'b1, any_phase(), 16'(remain)));
        end
        repeat ($urandom_range(1, 40))
            queue_tick(mk_tick(coin(), 1'b1, held_phase(), any16()));
        queue_tick(mk_tick(coin(), coin(), coin() ? PH_GREEN : any_phase(), any16()));
        drop_countdown = -1;
    endfunction

    function automatic void queue_random(int n);
        int target;
        target = queued_count + n;
        while (queued_count < target)
        begin
            if ($urandom_range(99) < 25)
                repeat ($urandom_range(1, 6))
                    queue_tick(mk_tick(coin(), coin(), any_phase(), any16()));
            else
                queue_crossing();
        end
    endfunction

    function automatic void queue_directed();
        queue_tick(mk_tick(1'b1, 1'b0, PH_RED, 16'd0));
        queue_tick(mk_tick(1'b0, 1'b1, PH_GREEN, 16'd0));
        queue_tick(mk_tick(1'b1, 1'b1, PH_OTHER, 16'hFFFF));
        queue_tick(mk_tick(1'b0, 1'b1, PH_OTHER, 16'd0));
        queue_tick(mk_tick(1'b0, 1'b1, PH_YELLOW, 16'd100));
        queue_tick(mk_tick(1'b0, 1'b1, PH_GREEN, 16'd100));
        queue_tick(mk_tick(1'b0, 1'b1, PH_RED, 16'hFFFF));
        queue_tick(mk_tick(1'b0, 1'b1, PH_RED, 16'd4));
        queue_tick(mk_tick(1'b0, 1'b1, PH_RED, 16'd3));
        queue_tick(mk_tick(1'b1, 1'b1, PH_OTHER, 16'd0));
        queue_tick(mk_tick(1'b0, 1'b1, PH_YELLOW, 16'd0));
        queue_tick(mk_tick(1'b0, 1'b1, PH_GREEN, 16'd0));
        queue_tick(mk_tick(1'b1, 1'b1, PH_GREEN, 16'd0));
        queue_tick(mk_tick(1'b0, 1'b1, PH_GREEN, 16'd0));
        queue_tick(mk_tick(1'b0, 1'b0, PH_RED, 16'd0));
        queue_tick(mk_tick(1'b1, 1'b1, PH_RED, 16'd0));
        queue_tick(mk_tick(1'b0, 1'b0, PH_RED, 16'd0));
        queue_tick(mk_tick(1'b1, 1'b1, PH_YELLOW, 16'd0));
        queue_tick(mk_tick(1'b0, 1'b1, PH_RED, 16'd0));
        queue_tick(mk_tick(1'b1, 1'b0, PH_RED, 16'd0));
        queue_tick(mk_tick(1'b1, 1'b1, PH_RED, 16'd0));
        queue_tick(mk_tick(1'b0, 1'b1, PH_RED, 16'd0));
        queue_tick(mk_tick(1'b0, 1'b1, PH_RED, 16'd0));
        queue_tick(mk_tick(1'b0, 1'b0, PH_RED, 16'hFFFF));
        queue_tick(mk_tick(1'b1, 1'b1, PH_OTHER, 16'hFFFF));
        queue_tick(mk_tick(1'b0, 1'b0, PH_GREEN, 16'd0));
    endfunction

    function automatic cfg_t random_setting();
        cfg_t c;
        int   unit;
        unit = coin() ? int'($urandom_range(50, 300)) : int'($urandom_range(1, 1000));
        c.tick_ms          = 10'(unit);
        c.stop_period      = 16'($urandom_range(0, 8 * unit));
        c.allow_period     = 16'($urandom_range(0, 10 * unit));
        c.stop_pulse       = 10'($urandom_range(0, 1023));
        c.allow_pulse      = 10'($urandom_range(0, 1023));
        c.louder_threshold = ($urandom_range(99) < 80) ? 16'($urandom_range(0, 20)) : any16();
        c.blink_period     = 16'($urandom_range(0, 4 * unit));
        return c;
    endfunction

    // call right after a rising edge; returns at the edge of the transfer
    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_TICK_MS:          shadow_cfg.tick_ms = data[9:0];
            CFG_STOP_PERIOD:      shadow_cfg.stop_period = data;
            CFG_ALLOW_PERIOD:     shadow_cfg.allow_period = data;
            CFG_STOP_PULSE:       shadow_cfg.stop_pulse = data[9:0];
            CFG_ALLOW_PULSE:      shadow_cfg.allow_pulse = data[9:0];
            CFG_LOUDER_THRESHOLD: shadow_cfg.louder_threshold = data;
            CFG_BLINK_PERIOD:     shadow_cfg.blink_period = data;
            default:              ;
        endcase
    endtask

    // upper bits of the 10-bit registers carry junk that must be dropped
    task automatic apply_setting(input cfg_t c);
        cfg_write(CFG_TICK_MS, {6'($urandom), c.tick_ms});
        cfg_write(CFG_STOP_PERIOD, c.stop_period);
        cfg_write(CFG_ALLOW_PERIOD, c.allow_period);
        cfg_write(CFG_STOP_PULSE, {6'($urandom), c.stop_pulse});
        cfg_write(CFG_ALLOW_PULSE, {6'($urandom), c.allow_pulse});
        cfg_write(CFG_LOUDER_THRESHOLD, c.louder_threshold);
        cfg_write(CFG_BLINK_PERIOD, c.blink_period);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_ticks.size() != 0 || tick_valid || expected_lamps.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        cfg_t setting;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int ph = 0; ph < PHASES; ph++)
        begin
            steady = (ph == 6);
            if (ph > 0)
            begin
                wait_drained();
                case (ph)
                    1: setting = '{tick_ms: 10'd1, default: '0};
                    2: setting = '{default: '1};
                    3:
                    begin
                        // zero tick: timers hold, only a zero period expires
                        setting = random_setting();
                        setting.tick_ms = 10'd0;
                        setting.stop_period = 16'd0;
                    end
                    default: setting = random_setting();
                endcase
                apply_setting(setting);
                if (ph == 4)
                    cfg_write(CFG_SPARE, 16'hFFFF);
                cfg_valid <= 1'b0;
            end
            if (ph == 0)
                queue_directed();
            queue_random(RANDOM_TICKS);
        end
        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
